// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts that a property holds at every rising clock edge outside reset.
`define M68KEA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Asserts that a condition never holds at a rising clock edge outside reset.
`define M68KEA_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== src/m68kea_pkg.sv =====
// Package with the transaction types and constants of the effective address unit.
package m68kea_pkg;

	// Register file geometry: D0-D7, A0-A7 and USP.
	localparam int REG_COUNT = 17;
	localparam int REG_AW = 5;
	localparam logic [4:0] REG_LAST = 5'd16;
	localparam logic [4:0] REG_USP = 5'd16;
	localparam logic [4:0] REG_PC = 5'd16;

	// Operand kinds.
	localparam logic [4:0] KIND_DREG     = 5'd0;
	localparam logic [4:0] KIND_AREG     = 5'd1;
	localparam logic [4:0] KIND_IND      = 5'd2;
	localparam logic [4:0] KIND_POSTINC  = 5'd3;
	localparam logic [4:0] KIND_PREDEC   = 5'd4;
	localparam logic [4:0] KIND_DISP     = 5'd5;
	localparam logic [4:0] KIND_INDEX    = 5'd6;
	localparam logic [4:0] KIND_ABSW     = 5'd7;
	localparam logic [4:0] KIND_ABSL     = 5'd8;
	localparam logic [4:0] KIND_PCDISP   = 5'd9;
	localparam logic [4:0] KIND_PCINDEX  = 5'd10;
	localparam logic [4:0] KIND_MOVEM    = 5'd11;
	localparam logic [4:0] KIND_BRANCH   = 5'd12;
	localparam logic [4:0] KIND_IMM      = 5'd13;
	localparam logic [4:0] KIND_SR       = 5'd14;
	localparam logic [4:0] KIND_USP      = 5'd15;
	localparam logic [4:0] KIND_CCR      = 5'd16;
	localparam logic [4:0] KIND_NOMEMIND = 5'd17;
	localparam logic [4:0] KIND_MEMIND   = 5'd18;
	localparam logic [4:0] KIND_POSTIDX  = 5'd19;
	localparam logic [4:0] KIND_PREIDX   = 5'd20;
	localparam logic [4:0] KIND_OTHER    = 5'd21;

	// Transaction modes.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EA    = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [4:0]         addr_kind;
		logic [4:0]         reg_number;
		logic [4:0]         idx_sel;
		logic               index_is_long;
		logic [1:0]         idx_scale;
		logic signed [31:0] displacement;
		logic [31:0]        value;
		logic [31:0]        instr_addr;
		logic               use_regs;
	} ea_item_t;

	typedef struct packed {
		logic [31:0] effective_address;
		logic        address_valid;
	} ea_result_t;

endpackage

// ===== src/m68kea_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module m68kea_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/m68k_effective_address_unit.sv =====
// Top level of the 68000-family effective address unit.
//
// One input channel (item_valid, item_stall, item) carries two kinds of
// transaction: a register write loads D0-D7, A0-A7 or USP into the register
// snapshot, and an address transaction computes one operand's effective
// address from the snapshot and the transaction's own fields. Every input
// transaction yields exactly one result transaction (result_valid,
// result_stall, result); a register write yields address zero, not valid.
// An accepted transaction is registered in the read stage along with its
// RAM reads, then in the result register. Throughput, while the receiver
// does not stall, is one transaction per cycle: the register snapshot
// reads its base and index registers from two copies of a 17-entry RAM in
// the cycle of acceptance, and the add happens in the following cycle.
// Reset clears the pipeline and marks all registers as never written, so
// they read as zero; no clearing pass is needed and the unit accepts work
// in the first cycle after reset. When the receiver stalls, the result
// register holds; one more transaction may wait in the read stage, and the
// input is stalled only when both are full.
module m68k_effective_address_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  m68kea_pkg::ea_item_t    item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output m68kea_pkg::ea_result_t  result
);

	import m68kea_pkg::*;

	logic                  accept;
	logic                  out_free;
	logic                  wr_en;
	logic                  rd_en;
	logic [REG_AW-1:0]     base_addr;
	logic [REG_AW-1:0]     idx_addr;
	logic [31:0]           base_rd;
	logic [31:0]           idx_rd;
	logic [REG_COUNT-1:0]  written_q;
	logic                  valid_s1;
	ea_item_t              item_s1;
	logic                  base_ok_s1;
	logic                  idx_ok_s1;
	logic                  result_valid_q;
	ea_result_t            result_q;
	logic [31:0]           base_val;
	logic [31:0]           idx_val;
	logic [31:0]           idx_ext;
	logic [31:0]           idx_scaled;
	logic [31:0]           disp;
	logic [31:0]           disp8;
	logic [31:0]           nomem_base;
	logic [31:0]           ea;
	logic                  ok;
	ea_result_t            result_d;

	// Handshake: the read stage moves on when the result register is free.
	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !out_free;
	assign accept     = item_valid && !item_stall;

	// Register writes go to both RAM copies; address transactions read them.
	assign wr_en = accept && (item.mode == MODE_WRITE) && (item.reg_number <= REG_LAST);
	assign rd_en = accept && (item.mode == MODE_EA);

	// Base register address: USP, any data or address register for the full format, else An.
	always_comb begin
		priority if (item.addr_kind == KIND_USP) begin
			base_addr = REG_USP;
		end else if (item.addr_kind == KIND_NOMEMIND) begin
			base_addr = {1'b0, item.reg_number[3:0]};
		end else begin
			base_addr = {2'b01, item.reg_number[2:0]};
		end
	end

	assign idx_addr = {1'b0, item.idx_sel[3:0]};

	m68kea_ram #(
		.WIDTH (32),
		.DEPTH (REG_COUNT)
	) u_base_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (item.reg_number),
		.wdata (item.value),
		.re    (rd_en),
		.raddr (base_addr),
		.rdata (base_rd)
	);

	m68kea_ram #(
		.WIDTH (32),
		.DEPTH (REG_COUNT)
	) u_index_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (item.reg_number),
		.wdata (item.value),
		.re    (rd_en),
		.raddr (idx_addr),
		.rdata (idx_rd)
	);

	// Written flags: a register never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[item.reg_number] <= 1'b1;
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Read stage payload, captured alongside the RAM reads.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= item;
			base_ok_s1 <= written_q[base_addr];
			idx_ok_s1  <= written_q[idx_addr];
		end
	end

	// Operands from the snapshot and the transaction.
	assign base_val   = base_ok_s1 ? base_rd : '0;
	assign idx_val    = (idx_ok_s1 && !item_s1.idx_sel[4]) ? idx_rd : '0;
	assign idx_ext    = item_s1.index_is_long ? idx_val : {{16{idx_val[15]}}, idx_val[15:0]};
	assign idx_scaled = idx_ext << item_s1.idx_scale;
	assign disp       = item_s1.displacement;
	assign disp8      = {{24{disp[7]}}, disp[7:0]};

	// Full-format base: a data or address register, the PC, or zero.
	always_comb begin
		priority if (!item_s1.reg_number[4]) begin
			nomem_base = base_val;
		end else if (item_s1.reg_number == REG_PC) begin
			nomem_base = item_s1.instr_addr;
		end else begin
			nomem_base = '0;
		end
	end

	// Effective address per operand kind.
	always_comb begin
		ea = '0;
		ok = 1'b0;
		if (item_s1.mode == MODE_EA) begin
			unique case (item_s1.addr_kind)
				KIND_IND, KIND_POSTINC, KIND_PREDEC: begin
					ea = base_val;
					ok = item_s1.use_regs;
				end
				KIND_DISP: begin
					ea = base_val + disp;
					ok = item_s1.use_regs;
				end
				KIND_INDEX: begin
					ea = base_val + idx_scaled + disp8;
					ok = item_s1.use_regs;
				end
				KIND_ABSW: begin
					ea = {{16{item_s1.value[15]}}, item_s1.value[15:0]};
					ok = 1'b1;
				end
				KIND_ABSL: begin
					ea = item_s1.value;
					ok = 1'b1;
				end
				KIND_PCDISP, KIND_BRANCH: begin
					ea = item_s1.instr_addr + disp;
					ok = 1'b1;
				end
				KIND_PCINDEX: begin
					ea = item_s1.instr_addr + disp
						+ (item_s1.use_regs ? idx_scaled : 32'd0);
					ok = 1'b1;
				end
				KIND_USP: begin
					ea = base_val;
					ok = item_s1.use_regs;
				end
				KIND_NOMEMIND, KIND_MEMIND, KIND_POSTIDX, KIND_PREIDX: begin
					if ((item_s1.addr_kind == KIND_NOMEMIND) && item_s1.use_regs) begin
						ea = nomem_base + idx_scaled + disp;
						ok = 1'b1;
					end else begin
						ea = item_s1.instr_addr + disp;
						ok = (item_s1.reg_number == REG_PC);
					end
				end
				default: begin
					ea = '0;
					ok = 1'b0;
				end
			endcase
		end
		result_d.effective_address = ok ? ea : '0;
		result_d.address_valid     = ok;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== src/m68kea_checker.sv =====
// Port-level checker for the effective address unit and its bind statement.
`include "assert_macros.svh"

module m68kea_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   item_valid,
	input logic                   item_stall,
	input m68kea_pkg::ea_item_t   item,
	input logic                   result_valid,
	input logic                   result_stall,
	input m68kea_pkg::ea_result_t result
);

	import m68kea_pkg::*;

	// A stalled result transaction keeps its payload.
	`M68KEA_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

	// An address that is not valid reads as zero.
	`M68KEA_NEVER(a_invalid_zero, result_valid && !result.address_valid && (result.effective_address != 32'd0), "invalid address not zero")

	// The input stalls only while a result waits on a stalled receiver.
	`M68KEA_NEVER(a_stall_cause, item_stall && !(result_valid && result_stall), "input stalled without backpressure")

	// An accepted transaction is followed by a valid result once it has passed the read stage.
	`M68KEA_ASSERT(a_latency, item_valid && !item_stall |=> ##1 result_valid, "result missing after acceptance")

endmodule

bind m68k_effective_address_unit m68kea_checker u_m68kea_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
